>>> src/smi_pkg.sv
package smi_pkg;

   localparam int DataWidth  = 32;
   localparam int CofWidth   = 66;
   localparam int DetWidth   = 100;
   localparam int QuotWidth  = 68;
   localparam int DivSteps   = QuotWidth;
   localparam int BitsPerStg = 2;
   localparam int DivStages  = DivSteps / BitsPerStg;
   localparam int NumEntries = 6;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SINGULAR = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic valid;
      logic size_two;
      logic last;
   } ctrl_type;

endpackage

>>> src/smi_cofactor.sv
module smi_cofactor (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic                                      in_size_two,
   input  logic                                      in_last,
   input  logic signed [smi_pkg::DataWidth-1:0]      a11,
   input  logic signed [smi_pkg::DataWidth-1:0]      a12,
   input  logic signed [smi_pkg::DataWidth-1:0]      a13,
   input  logic signed [smi_pkg::DataWidth-1:0]      a22,
   input  logic signed [smi_pkg::DataWidth-1:0]      a23,
   input  logic signed [smi_pkg::DataWidth-1:0]      a33,
   output smi_pkg::ctrl_type                         out_ctrl,
   output logic signed [smi_pkg::CofWidth-1:0]       out_cof [smi_pkg::NumEntries],
   output logic signed [smi_pkg::DetWidth-1:0]       out_det
);
   import smi_pkg::*;

   // stage 1: products
   ctrl_type                      c1_ff;
   logic signed [63:0]            p_ff [12];
   logic signed [DataWidth-1:0]   r11_ff, r12_ff, r13_ff, r22_ff;
   // stage 2: cofactors
   ctrl_type                      c2_ff;
   logic signed [CofWidth-1:0]    cof2_ff [NumEntries];
   logic signed [DataWidth-1:0]   s11_ff, s12_ff, s13_ff;
   // stage 3: det partial products (split 32x66 as 32x33 halves)
   ctrl_type                      c3_ff;
   logic signed [CofWidth-1:0]    cof3_ff [NumEntries];
   logic signed [66:0]            dlo_ff [3];
   logic signed [66:0]            dhi_ff [3];
   // stage 4: det
   ctrl_type                      c4_ff;
   logic signed [CofWidth-1:0]    cof4_ff [NumEntries];
   logic signed [DetWidth-1:0]    det4_ff;

   logic signed [CofWidth-1:0]    cof_in [NumEntries];
   logic signed [CofWidth-1:0]    cof4_in [NumEntries];
   logic signed [DetWidth-1:0]    det_in;
   logic signed [DetWidth-1:0]    lo_sum, hi_sum;

   always_comb begin
      if (c1_ff.size_two) begin
         cof_in[0] = CofWidth'(r22_ff);
         cof_in[1] = -CofWidth'(r12_ff);
         cof_in[2] = '0;
         cof_in[3] = CofWidth'(r11_ff);
         cof_in[4] = '0;
         cof_in[5] = CofWidth'(p_ff[10]) - CofWidth'(p_ff[11]);
      end else begin
         cof_in[0] = CofWidth'(p_ff[0]) - CofWidth'(p_ff[1]);
         cof_in[1] = CofWidth'(p_ff[2]) - CofWidth'(p_ff[3]);
         cof_in[2] = CofWidth'(p_ff[4]) - CofWidth'(p_ff[5]);
         cof_in[3] = CofWidth'(p_ff[6]) - CofWidth'(p_ff[7]);
         cof_in[4] = CofWidth'(p_ff[8]) - CofWidth'(p_ff[9]);
         cof_in[5] = CofWidth'(p_ff[10]) - CofWidth'(p_ff[11]);
      end
      lo_sum = DetWidth'(dlo_ff[0]) + DetWidth'(dlo_ff[1]) + DetWidth'(dlo_ff[2]);
      hi_sum = DetWidth'(dhi_ff[0]) + DetWidth'(dhi_ff[1]) + DetWidth'(dhi_ff[2]);
      cof4_in = cof3_ff;
      if (c3_ff.size_two) begin
         det_in = DetWidth'(cof3_ff[5]);
         cof4_in[5] = '0;
      end else begin
         det_in = (hi_sum <<< 33) + lo_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else begin
         c1_ff <= '{valid: in_valid, size_two: in_size_two, last: in_last};
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
      p_ff[0]  <= a33 * a22;
      p_ff[1]  <= a23 * a23;
      p_ff[2]  <= a23 * a13;
      p_ff[3]  <= a33 * a12;
      p_ff[4]  <= a23 * a12;
      p_ff[5]  <= a22 * a13;
      p_ff[6]  <= a33 * a11;
      p_ff[7]  <= a13 * a13;
      p_ff[8]  <= a12 * a13;
      p_ff[9]  <= a23 * a11;
      p_ff[10] <= a22 * a11;
      p_ff[11] <= a12 * a12;
      r11_ff <= a11;
      r12_ff <= a12;
      r13_ff <= a13;
      r22_ff <= a22;
      cof2_ff <= cof_in;
      s11_ff <= r11_ff;
      s12_ff <= r12_ff;
      s13_ff <= r13_ff;
      cof3_ff <= cof2_ff;
      dlo_ff[0] <= s11_ff * $signed({1'b0, cof2_ff[0][32:0]});
      dlo_ff[1] <= s12_ff * $signed({1'b0, cof2_ff[1][32:0]});
      dlo_ff[2] <= s13_ff * $signed({1'b0, cof2_ff[2][32:0]});
      dhi_ff[0] <= s11_ff * $signed(cof2_ff[0][65:33]);
      dhi_ff[1] <= s12_ff * $signed(cof2_ff[1][65:33]);
      dhi_ff[2] <= s13_ff * $signed(cof2_ff[2][65:33]);
      cof4_ff <= cof4_in;
      det4_ff <= det_in;
   end

   assign out_ctrl = c4_ff;
   assign out_cof  = cof4_ff;
   assign out_det  = det4_ff;

endmodule

>>> src/smi_divider.sv
module smi_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smi_pkg::ctrl_type                     in_ctrl,
   input  logic signed [smi_pkg::CofWidth-1:0]   in_cof [smi_pkg::NumEntries],
   input  logic signed [smi_pkg::DetWidth-1:0]   in_det,
   output smi_pkg::ctrl_type                     out_ctrl,
   output logic [smi_pkg::DataWidth-1:0]         out_inv [smi_pkg::NumEntries],
   output logic [1:0]                            out_status
);
   import smi_pkg::*;

   localparam int RemWidth = DetWidth;

   // per stage restoring division, BitsPerStg quotient bits each
   ctrl_type                  ctl_ff  [DivStages+1];
   logic                      zero_ff [DivStages+1];
   logic [NumEntries-1:0]     neg_ff  [DivStages+1];
   logic [NumEntries-1:0]     use_ff  [DivStages+1];
   logic [DetWidth-1:0]       den_ff  [DivStages+1];
   logic [QuotWidth-1:0]      num_ff  [DivStages+1][NumEntries];
   logic [RemWidth-1:0]       rem_ff  [DivStages+1][NumEntries];
   logic [QuotWidth-1:0]      quo_ff  [DivStages+1][NumEntries];

   logic [DetWidth-1:0]       det_abs;
   logic [CofWidth-1:0]       cof_abs [NumEntries];
   logic                      det_neg;

   always_comb begin
      det_neg = in_det[DetWidth-1];
      det_abs = det_neg ? DetWidth'(-in_det) : DetWidth'(in_det);
      for (int i = 0; i < NumEntries; i++) begin
         cof_abs[i] = in_cof[i][CofWidth-1] ? CofWidth'(-in_cof[i]) : CofWidth'(in_cof[i]);
      end
   end

   // stage 0 register: operands; numerator is |cof| << 32, its low 32 bits are zero
   // quotient fits below 2^QuotWidth after the leading-zero bits of |cof|<<32 are dropped:
   // quotient bits above QuotWidth would need |cof|*2^32 >= 2^QuotWidth * det, only possible
   // when det < 2^30; bits above are folded into an overflow flag via prefix
   logic [NumEntries-1:0]     big_ff [DivStages+1];
   logic [RemWidth-1:0]       rem0 [NumEntries];
   logic [NumEntries-1:0]     big0;

   always_comb begin
      for (int i = 0; i < NumEntries; i++) begin
         // numerator = cof_abs << 32 (98 bits); top 30 bits are prefix before QuotWidth steps
         rem0[i] = RemWidth'(cof_abs[i][CofWidth-1:CofWidth-30]);
         big0[i] = (RemWidth'(cof_abs[i][CofWidth-1:CofWidth-30]) >= det_abs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DivStages; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctrl;
         for (int s = 1; s <= DivStages; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
      zero_ff[0] <= (in_det == '0);
      den_ff[0]  <= det_abs;
      big_ff[0]  <= big0;
      for (int i = 0; i < NumEntries; i++) begin
         neg_ff[0][i] <= in_cof[i][CofWidth-1] ^ det_neg;
         use_ff[0][i] <= !(in_ctrl.size_two && (i == 2 || i == 4 || i == 5));
         num_ff[0][i] <= {cof_abs[i][CofWidth-31:0], 32'd0};
         rem_ff[0][i] <= rem0[i];
         quo_ff[0][i] <= '0;
      end
      for (int s = 1; s <= DivStages; s++) begin
         zero_ff[s] <= zero_ff[s-1];
         den_ff[s]  <= den_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         use_ff[s]  <= use_ff[s-1];
         big_ff[s]  <= big_ff[s-1];
         for (int i = 0; i < NumEntries; i++) begin
            logic [RemWidth:0]    r;
            logic [QuotWidth-1:0] n, q;
            r = {1'b0, rem_ff[s-1][i]};
            n = num_ff[s-1][i];
            q = quo_ff[s-1][i];
            for (int b = 0; b < BitsPerStg; b++) begin
               r = {r[RemWidth-1:0], n[QuotWidth-1]};
               n = n << 1;
               if (r >= {1'b0, den_ff[s-1]}) begin
                  r = r - {1'b0, den_ff[s-1]};
                  q = {q[QuotWidth-2:0], 1'b1};
               end else begin
                  q = {q[QuotWidth-2:0], 1'b0};
               end
            end
            rem_ff[s][i] <= r[RemWidth-1:0];
            num_ff[s][i] <= n;
            quo_ff[s][i] <= q;
         end
      end
   end

   logic [DataWidth-1:0]  res [NumEntries];
   logic [NumEntries-1:0] ovf;
   logic                  hi;
   logic [QuotWidth-1:0]  q;

   always_comb begin
      for (int i = 0; i < NumEntries; i++) begin
         q  = quo_ff[DivStages][i];
         hi = big_ff[DivStages][i] || (q[QuotWidth-1:DataWidth] != '0);
         ovf[i] = 1'b0;
         if (!use_ff[DivStages][i] || zero_ff[DivStages]) begin
            res[i] = '0;
         end else if (!neg_ff[DivStages][i]) begin
            if (hi || q[DataWidth-1]) begin
               res[i] = 32'h7FFF_FFFF;
               ovf[i] = 1'b1;
            end else begin
               res[i] = q[DataWidth-1:0];
            end
         end else begin
            if (hi || (q[DataWidth-1] && q[DataWidth-2:0] != '0)) begin
               res[i] = 32'h8000_0000;
               ovf[i] = 1'b1;
            end else begin
               res[i] = -q[DataWidth-1:0];
            end
         end
      end
   end

   assign out_ctrl = ctl_ff[DivStages];
   assign out_inv  = res;
   assign out_status = zero_ff[DivStages] ? STATUS_SINGULAR :
                       (ovf != '0) ? STATUS_OVERFLOW : STATUS_OK;

endmodule

>>> src/symmetric_matrix_inverse_core.sv
// path: start passes through the cofactor pipeline, the divider pipeline and an output register to rsp_valid
// throughput: one matrix per cycle, busy is always low
// the divider is a 34-stage restoring divider, two quotient bits per stage
// reset: synchronous, active high; clears pipeline valids, sets size_ff to 3
// the receiver cannot stall; each result is shown for exactly one cycle
module symmetric_matrix_inverse_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a11,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a12,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a13,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a22,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a23,
   input  logic signed [smi_pkg::DataWidth-1:0]  req_a33,
   input  logic                                  req_last_matrix,
   input  logic                                  csr_write,
   input  logic [1:0]                            csr_wdata,
   output logic                                  rsp_valid,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv11,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv12,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv13,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv22,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv23,
   output logic signed [smi_pkg::DataWidth-1:0]  rsp_inv33,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last_out
);
   import smi_pkg::*;

   logic [1:0]                   size_ff;
   ctrl_type                     cf_ctrl, dv_ctrl;
   logic signed [CofWidth-1:0]   cf_cof [NumEntries];
   logic signed [DetWidth-1:0]   cf_det;
   logic [DataWidth-1:0]         dv_inv [NumEntries];
   logic [1:0]                   dv_status;
   logic                         valid_ff;
   logic [DataWidth-1:0]         inv_ff [NumEntries];
   logic [1:0]                   status_ff;
   logic                         last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 2'd3;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            size_ff <= csr_wdata;
         end
         valid_ff <= dv_ctrl.valid;
      end
      inv_ff    <= dv_inv;
      status_ff <= dv_status;
      last_ff   <= dv_ctrl.last;
   end

   assign busy = 1'b0;

   smi_cofactor u_cofactor (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .in_size_two (size_ff == 2'd2),
      .in_last     (req_last_matrix),
      .a11         (req_a11),
      .a12         (req_a12),
      .a13         (req_a13),
      .a22         (req_a22),
      .a23         (req_a23),
      .a33         (req_a33),
      .out_ctrl    (cf_ctrl),
      .out_cof     (cf_cof),
      .out_det     (cf_det)
   );

   smi_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_ctrl    (cf_ctrl),
      .in_cof     (cf_cof),
      .in_det     (cf_det),
      .out_ctrl   (dv_ctrl),
      .out_inv    (dv_inv),
      .out_status (dv_status)
   );

   assign rsp_valid    = valid_ff;
   assign rsp_inv11    = inv_ff[0];
   assign rsp_inv12    = inv_ff[1];
   assign rsp_inv13    = inv_ff[2];
   assign rsp_inv22    = inv_ff[3];
   assign rsp_inv23    = inv_ff[4];
   assign rsp_inv33    = inv_ff[5];
   assign rsp_status   = status_ff;
   assign rsp_last_out = last_ff;

endmodule

>>> verif/tb_symmetric_matrix_inverse_core.sv
module tb_symmetric_matrix_inverse_core;
   timeunit 1ns;
   timeprecision 1ps;

   import smi_pkg::*;

   localparam int Latency = 40;

   typedef struct {
      logic signed [31:0] a11, a12, a13, a22, a23, a33;
      logic               last;
   } sym_matrix_type;

   typedef struct {
      logic [5:0][31:0] inv;
      logic [1:0]       status;
      logic             last;
   } inverse_type;

   typedef struct {
      logic [1:0]     size;
      sym_matrix_type m;
      logic           known;
      inverse_type    res;
   } directed_row_type;

   logic               clock, reset, start, busy;
   logic signed [31:0] req_a11, req_a12, req_a13, req_a22, req_a23, req_a33;
   logic               req_last_matrix, csr_write;
   logic [1:0]         csr_wdata;
   logic               rsp_valid;
   logic signed [31:0] rsp_inv11, rsp_inv12, rsp_inv13, rsp_inv22, rsp_inv23, rsp_inv33;
   logic [1:0]         rsp_status;
   logic               rsp_last_out;

   inverse_type pending_inverses[$];
   logic [1:0]  matrix_size;
   int          errors, beats_in, beats_out, n_singular, n_overflow;
   logic        use_typed;
   inverse_type typed_inverse;

   symmetric_matrix_inverse_core i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   function automatic inverse_type invert_matrix(sym_matrix_type m, logic [1:0] size);
      logic signed [127:0] a11, a12, a13, a22, a23, a33, det, q;
      logic signed [127:0] cof[6];
      logic [5:0]          used;
      inverse_type         r;
      a11 = m.a11; a12 = m.a12; a13 = m.a13;
      a22 = m.a22; a23 = m.a23; a33 = m.a33;
      for (int i = 0; i < 6; i++) cof[i] = 0;
      if (size == 2'd2) begin
         det = a11 * a22 - a12 * a12;
         cof[0] = a22; cof[1] = -a12; cof[3] = a11;
         used = 6'b001011;
      end else begin
         cof[0] = a33 * a22 - a23 * a23;
         cof[1] = a23 * a13 - a33 * a12;
         cof[2] = a23 * a12 - a22 * a13;
         cof[3] = a33 * a11 - a13 * a13;
         cof[4] = a12 * a13 - a23 * a11;
         cof[5] = a22 * a11 - a12 * a12;
         det = a11 * cof[0] + a12 * cof[1] + a13 * cof[2];
         used = 6'b111111;
      end
      r.inv = '0;
      r.last = m.last;
      r.status = STATUS_OK;
      if (det == 0) begin
         r.status = STATUS_SINGULAR;
      end else begin
         for (int i = 0; i < 6; i++) begin
            if (used[i]) begin
               q = (cof[i] <<< 32) / det;
               if (q > 128'sh7FFFFFFF) begin
                  r.inv[i] = 32'h7FFFFFFF;
                  r.status = STATUS_OVERFLOW;
               end else if (q < -128'sh80000000) begin
                  r.inv[i] = 32'h80000000;
                  r.status = STATUS_OVERFLOW;
               end else begin
                  r.inv[i] = q[31:0];
               end
            end
         end
      end
      return r;
   endfunction

   // scoreboard: push on accepted beat, compare on strobe
   always @(posedge clock) begin
      logic [5:0][31:0] got;
      inverse_type      exp_r;
      if (!reset) begin
         if (start && !busy) begin
            pending_inverses.push_back(use_typed ? typed_inverse
                                                 : invert_matrix('{req_a11, req_a12, req_a13,
                                                   req_a22, req_a23, req_a33, req_last_matrix},
                                                   matrix_size));
            beats_in++;
         end
         if (rsp_valid) begin
            beats_out++;
            got = {rsp_inv33, rsp_inv23, rsp_inv22, rsp_inv13, rsp_inv12, rsp_inv11};
            if (pending_inverses.size() == 0) begin
               $display("%0t: result beat with nothing expected", $time);
               errors++;
            end else begin
               exp_r = pending_inverses.pop_front();
               if (exp_r.status == STATUS_SINGULAR) n_singular++;
               if (exp_r.status == STATUS_OVERFLOW) n_overflow++;
               for (int i = 0; i < 6; i++)
                  if (got[i] !== exp_r.inv[i]) begin
                     $display("%0t: inv entry %0d expected %h got %h", $time, i,
                              exp_r.inv[i], got[i]);
                     errors++;
                  end
               if (rsp_status !== exp_r.status) begin
                  $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                           rsp_status);
                  errors++;
               end
               if (rsp_last_out !== exp_r.last) begin
                  $display("%0t: last expected %b got %b", $time, exp_r.last, rsp_last_out);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_matrix(sym_matrix_type m, logic known, inverse_type res);
      @(negedge clock);
      {req_a11, req_a12, req_a13, req_a22, req_a23, req_a33, req_last_matrix} =
         {m.a11, m.a12, m.a13, m.a22, m.a23, m.a33, m.last};
      use_typed = known;
      typed_inverse = res;
      start = 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst();
      int n;
      n = $urandom_range(1, 12);
      @(negedge clock);
      start = 0;
      use_typed = 0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic set_size(logic [1:0] size);
      @(negedge clock);
      start = 0;
      while (pending_inverses.size() != 0) @(negedge clock);
      repeat (Latency + 5) @(negedge clock);
      csr_write = 1;
      csr_wdata = size;
      matrix_size = size;
      @(negedge clock);
      csr_write = 0;
   endtask

   function automatic logic signed [31:0] random_entry();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
         2: case ($urandom_range(0, 5))
               0: return 0;
               1: return 1;
               2: return -1;
               3: return 32'sh7FFFFFFF;
               4: return 32'sh80000000;
               default: return 32'sh00010000;
            endcase
         default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   function automatic inverse_type diag_inv(logic [31:0] d, logic [31:0] d3,
                                            status_type st, logic last);
      inverse_type r;
      r.inv = '0;
      r.inv[0] = d; r.inv[3] = d; r.inv[5] = d3;
      r.status = st;
      r.last = last;
      return r;
   endfunction

   directed_row_type directed[] = '{
      '{2'd3, '{32'h10000, 0, 0, 32'h10000, 0, 32'h10000, 1'b1}, 1'b1,
        diag_inv(32'h10000, 32'h10000, STATUS_OK, 1'b1)},
      '{2'd3, '{0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, diag_inv(0, 0, STATUS_SINGULAR, 1'b0)},
      '{2'd3, '{1, 0, 0, 1, 0, 1, 1'b0}, 1'b1,
        diag_inv(32'h7FFFFFFF, 32'h7FFFFFFF, STATUS_OVERFLOW, 1'b0)},
      '{2'd3, '{-1, 0, 0, -1, 0, -1, 1'b1}, 1'b1,
        diag_inv(32'h80000000, 32'h80000000, STATUS_OVERFLOW, 1'b1)},
      '{2'd3, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h7FFFFFFF, 1'b0}, 1'b1, diag_inv(0, 0, STATUS_SINGULAR, 1'b0)},
      '{2'd3, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 1'b1}, 1'b1, diag_inv(0, 0, STATUS_SINGULAR, 1'b1)},
      '{2'd3, '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
        32'h7FFFFFFF, 1'b0}, 1'b0, '{default: 0}},
      '{2'd3, '{32'h30000, 32'h8000, -32'h4000, 32'h20000, 32'h1000, 32'h50000, 1'b0},
        1'b0, '{default: 0}},
      '{2'd3, '{32'h7FFFFFFF, 1, -1, 32'h80000000, 32'h10000, 32'h7FFFFFFF, 1'b1},
        1'b0, '{default: 0}},
      '{2'd2, '{32'h10000, 0, 32'h7FFFFFFF, 32'h10000, 32'h80000000, -1, 1'b1}, 1'b1,
        diag_inv(32'h10000, 0, STATUS_OK, 1'b1)},
      '{2'd2, '{0, 0, 5, 0, 7, 9, 1'b0}, 1'b1, diag_inv(0, 0, STATUS_SINGULAR, 1'b0)},
      '{2'd2, '{1, 0, 0, 1, 0, 0, 1'b0}, 1'b1,
        diag_inv(32'h7FFFFFFF, 0, STATUS_OVERFLOW, 1'b0)},
      '{2'd2, '{32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 1'b1}, 1'b0,
        '{default: 0}},
      '{2'd2, '{32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 0, 0, 1'b0}, 1'b0,
        '{default: 0}},
      '{2'd2, '{32'h20000, -32'h8000, 3, 32'h30000, 4, 5, 1'b0}, 1'b0, '{default: 0}},
      '{2'd0, '{32'h10000, 0, 0, 32'h10000, 0, 32'h10000, 1'b1}, 1'b1,
        diag_inv(32'h10000, 32'h10000, STATUS_OK, 1'b1)},
      '{2'd1, '{-32'h10000, 0, 0, -32'h10000, 0, -32'h10000, 1'b0}, 1'b1,
        diag_inv(32'hFFFF0000, 32'hFFFF0000, STATUS_OK, 1'b0)}
   };

   initial begin
      sym_matrix_type m;
      logic [1:0]     sizes[5] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
      start = 0; use_typed = 0; csr_write = 0; csr_wdata = 0;
      {req_a11, req_a12, req_a13, req_a22, req_a23, req_a33, req_last_matrix} = '0;
      typed_inverse = '{default: 0};
      errors = 0; beats_in = 0; beats_out = 0; n_singular = 0; n_overflow = 0;
      matrix_size = 2'd3;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[i]) begin
         if (directed[i].size != matrix_size) set_size(directed[i].size);
         send_matrix(directed[i].m, directed[i].known, directed[i].res);
      end

      foreach (sizes[p]) begin
         set_size(sizes[p]);
         for (int k = 0; k < 230; k++) begin
            m = '{random_entry(), random_entry(), random_entry(), random_entry(),
                  random_entry(), random_entry(), 1'($urandom)};
            if ($urandom_range(0, 9) == 0) begin
               if (matrix_size == 2'd2) begin
                  m.a11 = m.a12; m.a22 = m.a12;
               end else begin
                  m.a13 = m.a12; m.a23 = m.a22; m.a33 = m.a22;
               end
            end
            send_matrix(m, 1'b0, typed_inverse);
            if (!(p == 4 && k > 130) && $urandom_range(0, 5) == 0) idle_burst();
         end
      end

      @(negedge clock);
      start = 0;
      while (pending_inverses.size() != 0) @(negedge clock);
      repeat (Latency + 5) @(posedge clock);
      $display("%0d matrices in, %0d results checked over sizes 3, 2, 0 and 1",
               beats_in, beats_out);
      $display("%0d singular and %0d saturated results seen", n_singular, n_overflow);
      if (errors == 0 && pending_inverses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/smi_pkg.sv
src/smi_cofactor.sv
src/smi_divider.sv
src/symmetric_matrix_inverse_core.sv
verif/tb_symmetric_matrix_inverse_core.sv
